/* hdl/vbc_pkg.sv */
// ----------------------------------------------------------------------------
// vbc_pkg: shared types and constants for the voxel boundary classifier
// Grid size, class codes, register indexes and the grid port structs.
// ----------------------------------------------------------------------------
package vbc_pkg;

  localparam int MAX_DIM = 64;
  localparam int ROW_W   = $clog2(MAX_DIM);   // row / column index bits
  localparam int CNT_W   = ROW_W + 1;         // sizes up to MAX_DIM itself
  localparam int CFG_W   = 7;                 // widest register
  localparam int CFG_IDX_W = 2;

  typedef logic [MAX_DIM-1:0] row_t;

  // voxel classes
  localparam logic [1:0] CLS_EMPTY  = 2'd0;
  localparam logic [1:0] CLS_CORNER = 2'd1;
  localparam logic [1:0] CLS_EDGE   = 2'd2;
  localparam logic [1:0] CLS_INSIDE = 2'd3;

  // item kinds
  localparam logic MODE_WRITE    = 1'b0;
  localparam logic MODE_CLASSIFY = 1'b1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 2'd1;

  // request from the control logic to the grid store
  typedef struct packed {
    logic             rd_en;
    logic [ROW_W-1:0] rd_row;
    logic             wr_en;
    logic [ROW_W-1:0] wr_row;
    row_t             wr_data;
  } grid_req_t;

  // rows around the read row, never-written rows read as empty
  typedef struct packed {
    row_t up;   // row - 1
    row_t mid;  // row
    row_t dn;   // row + 1
  } grid_rows_t;

endpackage

/* hdl/vbc_grid.sv */
// ----------------------------------------------------------------------------
// vbc_grid: occupancy grid store
// Three copies of the row memory, one read port each, so a single read
// returns a row and both of its vertical neighbours. Per-row valid bits
// make the grid read as clear after reset.
// ----------------------------------------------------------------------------
module vbc_grid import vbc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  grid_req_t  req_i,
  output grid_rows_t rows_o
);

  row_t mem_up  [MAX_DIM];
  row_t mem_mid [MAX_DIM];
  row_t mem_dn  [MAX_DIM];

  logic [MAX_DIM-1:0] row_vld_q;

  row_t up_q, mid_q, dn_q;
  logic up_vld_q, mid_vld_q, dn_vld_q;

  logic [ROW_W-1:0] row_m1, row_p1;

  assign row_m1 = req_i.rd_row - ROW_W'(1);
  assign row_p1 = req_i.rd_row + ROW_W'(1);

  // all copies take every write
  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_up[req_i.wr_row]  <= req_i.wr_data;
      mem_mid[req_i.wr_row] <= req_i.wr_data;
      mem_dn[req_i.wr_row]  <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      up_q  <= mem_up[row_m1];
      mid_q <= mem_mid[req_i.rd_row];
      dn_q  <= mem_dn[row_p1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
      up_vld_q  <= 1'b0;
      mid_vld_q <= 1'b0;
      dn_vld_q  <= 1'b0;
    end else begin
      if (req_i.wr_en) begin
        row_vld_q[req_i.wr_row] <= 1'b1;
      end
      if (req_i.rd_en) begin
        up_vld_q  <= row_vld_q[row_m1];
        mid_vld_q <= row_vld_q[req_i.rd_row];
        dn_vld_q  <= row_vld_q[row_p1];
      end
    end
  end

  assign rows_o.up  = up_vld_q  ? up_q  : '0;
  assign rows_o.mid = mid_vld_q ? mid_q : '0;
  assign rows_o.dn  = dn_vld_q  ? dn_q  : '0;

endmodule

/* hdl/voxel_boundary_classifier_top.sv */
// ----------------------------------------------------------------------------
// voxel_boundary_classifier_top: occupancy grid with boundary classification
// Write items set or clear one voxel; classify items return empty, corner,
// edge or inside for one voxel, judged against its eight neighbours.
// ----------------------------------------------------------------------------
//
//  channel   dir  tdata (low bit up)                  tuser
//  s_axis    in   col[5:0] row[11:6] occupied[12]     mode (0 write, 1 classify)
//  m_axis    out  voxel_class[1:0] on_boundary[2]     -
//  cfg       in   index 0 grid_width, 1 grid_height   -
//
//  Each item first reads the row memories, then is classified or has its
//  modified row written back; no new item is taken until it is done.
//  Reset leaves the grid clear at once (per-row valid bits, no clear sweep).
//  A finished result waits in the output register while the next item is
//  taken; a classify stalls after its read only if that register is
//  still full and not being drained.
//
module voxel_boundary_classifier_top import vbc_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // input items
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [15:0]          s_axis_tdata,   // col, row, occupied, zero fill
  input  logic                 s_axis_tuser,   // mode
  // results
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [7:0]           m_axis_tdata,   // voxel_class, on_boundary, zero fill
  // register writes
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i
);

  typedef enum logic {ST_IDLE, ST_BUSY} state_e;

  state_e           state_q;
  logic             mode_q;
  logic [ROW_W-1:0] col_q, row_q;
  logic             occ_q;
  logic             out_vld_q;
  logic [1:0]       cls_q;
  logic             bnd_q;
  logic [CFG_W-1:0] gw_q, gh_q;

  grid_req_t  grid_req;
  grid_rows_t rows;

  logic             accept;
  logic [ROW_W-1:0] in_col, in_row;
  logic             in_occ;
  logic             out_free;
  logic             load_out;

  assign in_col = s_axis_tdata[ROW_W-1:0];
  assign in_row = s_axis_tdata[2*ROW_W-1:ROW_W];
  assign in_occ = s_axis_tdata[2*ROW_W];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_vld_q || m_axis_tready;
  assign load_out      = (state_q == ST_BUSY) && (mode_q == MODE_CLASSIFY) && out_free;

  // --- configuration --------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gw_q <= CFG_W'(MAX_DIM);
      gh_q <= CFG_W'(MAX_DIM);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_GRID_WIDTH:  gw_q <= cfg_wdata_i;
        CFG_GRID_HEIGHT: gh_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // sizes above the store act as the full store
  logic [CNT_W-1:0] used_w, used_h;
  assign used_w = (gw_q > CFG_W'(MAX_DIM)) ? CNT_W'(MAX_DIM) : CNT_W'(gw_q);
  assign used_h = (gh_q > CFG_W'(MAX_DIM)) ? CNT_W'(MAX_DIM) : CNT_W'(gh_q);

  // --- grid store -----------------------------------------------------------
  row_t wr_row_data;
  always_comb begin
    wr_row_data         = rows.mid;
    wr_row_data[col_q]  = occ_q;
  end

  assign grid_req.rd_en   = accept;
  assign grid_req.rd_row  = in_row;
  assign grid_req.wr_en   = (state_q == ST_BUSY) && (mode_q == MODE_WRITE);
  assign grid_req.wr_row  = row_q;
  assign grid_req.wr_data = wr_row_data;

  vbc_grid u_grid (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (grid_req),
    .rows_o (rows)
  );

  // --- classification -------------------------------------------------------
  logic [CNT_W-1:0] x_ext, y_ext;
  logic [ROW_W-1:0] col_m1, col_p1;
  logic col_lo_ok, col_ok, col_hi_ok, row_lo_ok, row_ok, row_hi_ok;
  logic f_ul, f_u, f_ur, f_l, f_c, f_r, f_dl, f_d, f_dr;
  logic is_corner, is_edge;
  logic [1:0] cls_d;

  assign x_ext  = CNT_W'(col_q);
  assign y_ext  = CNT_W'(row_q);
  assign col_m1 = col_q - ROW_W'(1);   // wraps at 0, masked by col_lo_ok
  assign col_p1 = col_q + ROW_W'(1);   // wraps at top, masked by col_hi_ok

  assign col_lo_ok = (col_q != '0) && ((x_ext - CNT_W'(1)) < used_w);
  assign col_ok    = x_ext < used_w;
  assign col_hi_ok = (x_ext + CNT_W'(1)) < used_w;
  assign row_lo_ok = (row_q != '0) && ((y_ext - CNT_W'(1)) < used_h);
  assign row_ok    = y_ext < used_h;
  assign row_hi_ok = (y_ext + CNT_W'(1)) < used_h;

  // neighbour occupancy, out of range reads empty
  assign f_ul = row_lo_ok && col_lo_ok && rows.up[col_m1];
  assign f_u  = row_lo_ok && col_ok    && rows.up[col_q];
  assign f_ur = row_lo_ok && col_hi_ok && rows.up[col_p1];
  assign f_l  = row_ok    && col_lo_ok && rows.mid[col_m1];
  assign f_c  = row_ok    && col_ok    && rows.mid[col_q];
  assign f_r  = row_ok    && col_hi_ok && rows.mid[col_p1];
  assign f_dl = row_hi_ok && col_lo_ok && rows.dn[col_m1];
  assign f_d  = row_hi_ok && col_ok    && rows.dn[col_q];
  assign f_dr = row_hi_ok && col_hi_ok && rows.dn[col_p1];

  // corner: some diagonal and both orthogonals toward it are empty
  assign is_corner = (!f_dr && !f_r && !f_d) || (!f_dl && !f_l && !f_d) ||
                     (!f_ur && !f_r && !f_u) || (!f_ul && !f_l && !f_u);
  assign is_edge   = !f_r || !f_l || !f_d || !f_u;

  always_comb begin
    if (!f_c) begin
      cls_d = CLS_EMPTY;
    end else if (is_corner) begin
      cls_d = CLS_CORNER;
    end else if (is_edge) begin
      cls_d = CLS_EDGE;
    end else begin
      cls_d = CLS_INSIDE;
    end
  end

  // --- control and output register -----------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      mode_q    <= MODE_WRITE;
      col_q     <= '0;
      row_q     <= '0;
      occ_q     <= 1'b0;
      out_vld_q <= 1'b0;
      cls_q     <= CLS_EMPTY;
      bnd_q     <= 1'b0;
    end else begin
      // a new result refills the register in the cycle the old one leaves
      if (load_out) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            mode_q  <= s_axis_tuser;
            col_q   <= in_col;
            row_q   <= in_row;
            occ_q   <= in_occ;
            state_q <= ST_BUSY;
          end
        end
        ST_BUSY: begin
          if (mode_q == MODE_WRITE) begin
            state_q <= ST_IDLE;
          end else if (out_free) begin
            cls_q     <= cls_d;
            bnd_q     <= (cls_d == CLS_CORNER) || (cls_d == CLS_EDGE);
            state_q   <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {5'd0, bnd_q, cls_q};

`ifndef SYNTHESIS
  // an accepted item puts the block in its busy state, so it is not ready
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !s_axis_tready)
    else $error("item accepted on back-to-back cycles");

  // a write item never raises a result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_BUSY && mode_q == MODE_WRITE && !out_vld_q) |=> !out_vld_q)
    else $error("write item produced a result");

  // result is only loaded when the output register can take it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |-> (!out_vld_q || m_axis_tready))
    else $error("result overwritten before transfer");

  // boundary flag agrees with the class
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (bnd_q == ((cls_q == CLS_CORNER) || (cls_q == CLS_EDGE))))
    else $error("boundary flag mismatch");
`endif

endmodule
